// ----- src/bots_pkg.sv -----
// Package for the bulk-only transport sequencer.
// Holds the event, result and configuration types plus the bus and completion codes.
// No dependencies.
`default_nettype none

package bots_pkg;

   // Event codes carried by the action field
   localparam logic [2:0] ACT_START         = 3'd0;
   localparam logic [2:0] ACT_WRAPPER_SENT  = 3'd1;
   localparam logic [2:0] ACT_DATA_DONE     = 3'd2;
   localparam logic [2:0] ACT_STATUS_READ   = 3'd3;
   localparam logic [2:0] ACT_PIPE_DONE     = 3'd4;
   localparam logic [2:0] ACT_RECOVERY_DONE = 3'd5;

   // Transfer status codes
   localparam logic [1:0] XS_SUCCESS   = 2'd0;
   localparam logic [1:0] XS_STALLED   = 2'd1;
   localparam logic [1:0] XS_CANCELLED = 2'd2;

   // Bus commands issued on the result channel
   localparam logic [2:0] CMD_WRAPPER    = 3'd0;
   localparam logic [2:0] CMD_DATA_IN    = 3'd1;
   localparam logic [2:0] CMD_DATA_OUT   = 3'd2;
   localparam logic [2:0] CMD_STATUS     = 3'd3;
   localparam logic [2:0] CMD_CLEAR_PIPE = 3'd4;
   localparam logic [2:0] CMD_RECOVERY   = 3'd5;
   localparam logic [2:0] CMD_COMPLETE   = 3'd6;

   // Completion codes
   localparam logic [2:0] CC_SUCCESS      = 3'd0;
   localparam logic [2:0] CC_DEV_ERROR    = 3'd1;
   localparam logic [2:0] CC_CANCELLED    = 3'd2;
   localparam logic [2:0] CC_XFER_ERROR   = 3'd3;
   localparam logic [2:0] CC_INVALID      = 3'd4;
   localparam logic [2:0] CC_RESET_FAILED = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_ALT_SIG_EN  = 2'd0;
   localparam logic [1:0] CSR_ALT_SIG     = 2'd1;
   localparam logic [1:0] CSR_SENSE_FORM  = 2'd2;
   localparam logic [1:0] CSR_MAX_LENGTH  = 2'd3;

   // Sense cdb forms
   localparam logic [1:0] SENSE_FORM_LONG  = 2'd0;
   localparam logic [1:0] SENSE_FORM_SHORT = 2'd1;

   // Protocol constants
   localparam logic [31:0] CSW_GOOD_SIG    = 32'h5342_5355;
   localparam logic [31:0] CBW_BYTES       = 32'd31;
   localparam logic [31:0] CSW_BYTES       = 32'd13;
   localparam logic [7:0]  SENSE_MIN       = 8'd18;
   localparam logic [4:0]  SENSE_CB_LONG   = 5'd12;
   localparam logic [4:0]  SENSE_CB_SHORT  = 5'd6;
   localparam logic [1:0]  SENSE_FORM_RST  = 2'd1;
   localparam logic [31:0] MAX_LENGTH_RST  = 32'd65536;

   // Transport phase, one-hot
   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_WRAPPER  = 6'b000010,
      PH_DATA     = 6'b000100,
      PH_STATUS   = 6'b001000,
      PH_PIPE     = 6'b010000,
      PH_RECOVERY = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [1:0]  xfer_status;
      logic [31:0] byte_count;
      logic        dir_in;
      logic [3:0]  lun;
      logic [4:0]  cb_bytes;
      logic        want_sense;
      logic [7:0]  sense_length;
      logic        has_data;
      logic [31:0] status_sig;
      logic [7:0]  csw_status;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] xfer_length;
      logic        wrapper_dir_in;
      logic [3:0]  wrapper_lun;
      logic [4:0]  wrapper_cb_length;
      logic        is_sense_wrapper;
      logic [7:0]  sense_lun_byte;
      logic [2:0]  complete_code;
      logic        forge_good_sense;
      logic        clear_pass_length;
   } rsp_item_type;

   typedef struct packed {
      logic        alt_sig_en;
      logic [31:0] alt_sig;
      logic [1:0]  sense_form;
      logic [31:0] max_length;
   } cfg_type;

endpackage

`default_nettype wire

// ----- src/bots_csr.sv -----
// Configuration registers of the bulk-only transport sequencer.
// Depends on bots_pkg.
`default_nettype none

module bots_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata,
   output bots_pkg::cfg_type     cfg
);
   import bots_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ALT_SIG_EN: cfg_in.alt_sig_en = csr_wdata[0];
            CSR_ALT_SIG:    cfg_in.alt_sig    = csr_wdata;
            CSR_SENSE_FORM: cfg_in.sense_form = csr_wdata[1:0];
            CSR_MAX_LENGTH: cfg_in.max_length = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alt_sig_en <= 1'b0;
         cfg_ff.alt_sig    <= '0;
         cfg_ff.sense_form <= SENSE_FORM_RST;
         cfg_ff.max_length <= MAX_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/bots_core.sv -----
// Phase sequencer: request state and the decision logic for one event.
// Depends on bots_pkg.
`default_nettype none

module bots_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire bots_pkg::req_item_type item,
   input  wire bots_pkg::cfg_type     cfg,
   output logic                       rsp_hit,
   output bots_pkg::rsp_item_type     rsp
);
   import bots_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        sense_ff, sense_in;
   logic        retry_ff, retry_in;
   logic        dir_ff, dir_in;
   logic [31:0] length_ff, length_in;
   logic        want_ff, want_in;
   logic [7:0]  sense_len_ff, sense_len_in;
   logic [3:0]  lun_ff, lun_in;

   logic        cbw_fits;
   logic        csw_fits;
   logic        sig_ok;
   logic [31:0] data_len;
   logic        data_dir;
   logic [4:0]  sense_cbl;
   logic        sense_form_ok;

   function automatic rsp_item_type make_cmd(input logic [2:0] cmd, input logic [31:0] len);
      rsp_item_type r;
      r = '0;
      r.command = cmd;
      r.xfer_length = len;
      return r;
   endfunction

   function automatic rsp_item_type make_done(input logic [2:0] code);
      rsp_item_type r;
      r = '0;
      r.command = CMD_COMPLETE;
      r.complete_code = code;
      return r;
   endfunction

   function automatic logic [2:0] map_fail(input logic [1:0] xs);
      return (xs == XS_CANCELLED) ? CC_CANCELLED : CC_XFER_ERROR;
   endfunction

   // Shared checks
   assign cbw_fits = (cfg.max_length >= CBW_BYTES);
   assign csw_fits = (cfg.max_length >= CSW_BYTES);
   assign sig_ok   = (item.status_sig == CSW_GOOD_SIG) ||
                     (cfg.alt_sig_en && (item.status_sig == cfg.alt_sig));
   assign data_len = sense_ff ? {24'd0, sense_len_ff} : length_ff;
   assign data_dir = sense_ff | dir_ff;
   assign sense_form_ok = (cfg.sense_form == SENSE_FORM_LONG) ||
                          (cfg.sense_form == SENSE_FORM_SHORT);
   assign sense_cbl = (cfg.sense_form == SENSE_FORM_LONG) ? SENSE_CB_LONG : SENSE_CB_SHORT;

   // Event decision
   always_comb begin
      phase_in     = phase_ff;
      sense_in     = sense_ff;
      retry_in     = retry_ff;
      dir_in       = dir_ff;
      length_in    = length_ff;
      want_in      = want_ff;
      sense_len_in = sense_len_ff;
      lun_in       = lun_ff;
      rsp_hit      = 1'b0;
      rsp          = '0;

      if (fire) begin
         unique case (item.action)
            ACT_START: begin
               length_in    = item.byte_count;
               dir_in       = item.dir_in;
               lun_in       = item.lun;
               want_in      = item.want_sense;
               sense_len_in = item.sense_length;
               retry_in     = 1'b1;
               sense_in     = 1'b0;
               rsp_hit      = 1'b1;
               if (!cbw_fits) begin
                  rsp      = make_done(CC_INVALID);
                  phase_in = PH_IDLE;
               end else begin
                  rsp                   = make_cmd(CMD_WRAPPER, item.byte_count);
                  rsp.wrapper_dir_in    = item.dir_in;
                  rsp.wrapper_lun       = item.lun;
                  rsp.wrapper_cb_length = item.cb_bytes;
                  phase_in              = PH_WRAPPER;
               end
            end

            ACT_WRAPPER_SENT: begin
               if (phase_ff == PH_WRAPPER) begin
                  rsp_hit = 1'b1;
                  if (item.xfer_status == XS_STALLED) begin
                     rsp      = make_cmd(CMD_RECOVERY, '0);
                     phase_in = PH_RECOVERY;
                  end else if (item.xfer_status != XS_SUCCESS) begin
                     rsp      = make_done(map_fail(item.xfer_status));
                     phase_in = PH_IDLE;
                  end else if (!item.has_data) begin
                     if (csw_fits) begin
                        rsp      = make_cmd(CMD_STATUS, CSW_BYTES);
                        phase_in = PH_STATUS;
                     end else begin
                        rsp      = make_done(CC_INVALID);
                        phase_in = PH_IDLE;
                     end
                  end else if (data_len > cfg.max_length) begin
                     rsp      = make_done(CC_INVALID);
                     phase_in = PH_IDLE;
                  end else begin
                     rsp      = make_cmd(data_dir ? CMD_DATA_IN : CMD_DATA_OUT, data_len);
                     phase_in = PH_DATA;
                  end
               end
            end

            ACT_DATA_DONE: begin
               if (phase_ff == PH_DATA) begin
                  rsp_hit = 1'b1;
                  if (item.xfer_status == XS_SUCCESS) begin
                     if (csw_fits) begin
                        rsp      = make_cmd(CMD_STATUS, CSW_BYTES);
                        phase_in = PH_STATUS;
                     end else begin
                        rsp      = make_done(CC_INVALID);
                        phase_in = PH_IDLE;
                     end
                  end else begin
                     // failed data phase: drop the pass-through length
                     if (item.xfer_status == XS_STALLED) begin
                        rsp      = make_cmd(CMD_CLEAR_PIPE, '0);
                        phase_in = PH_PIPE;
                     end else begin
                        rsp      = make_done(map_fail(item.xfer_status));
                        phase_in = PH_IDLE;
                     end
                     rsp.clear_pass_length = 1'b1;
                  end
               end
            end

            ACT_STATUS_READ: begin
               if (phase_ff == PH_STATUS) begin
                  rsp_hit = 1'b1;
                  if ((item.xfer_status == XS_SUCCESS) && sig_ok) begin
                     if (item.csw_status == 8'd0) begin
                        rsp                  = make_done(CC_SUCCESS);
                        rsp.forge_good_sense = !sense_ff && want_ff;
                        phase_in             = PH_IDLE;
                     end else if ((item.csw_status == 8'd1) && want_ff && !sense_ff) begin
                        // automatic request sense
                        if ((sense_len_ff < SENSE_MIN) || !sense_form_ok || !cbw_fits) begin
                           rsp      = make_done(CC_DEV_ERROR);
                           phase_in = PH_IDLE;
                        end else begin
                           rsp                   = make_cmd(CMD_WRAPPER, {24'd0, sense_len_ff});
                           rsp.wrapper_dir_in    = 1'b1;
                           rsp.wrapper_cb_length = sense_cbl;
                           rsp.is_sense_wrapper  = 1'b1;
                           rsp.sense_lun_byte    = {lun_ff[2:0], 5'd0};
                           retry_in              = 1'b1;
                           sense_in              = 1'b1;
                           phase_in              = PH_WRAPPER;
                        end
                     end else begin
                        rsp      = make_cmd(CMD_RECOVERY, '0);
                        phase_in = PH_RECOVERY;
                     end
                  end else if ((item.xfer_status == XS_STALLED) && retry_ff) begin
                     // one status retry after a stall
                     retry_in = 1'b0;
                     rsp      = make_cmd(CMD_CLEAR_PIPE, '0);
                     phase_in = PH_PIPE;
                  end else if (item.xfer_status != XS_CANCELLED) begin
                     rsp      = make_cmd(CMD_RECOVERY, '0);
                     phase_in = PH_RECOVERY;
                  end else begin
                     rsp      = make_done(CC_CANCELLED);
                     phase_in = PH_IDLE;
                  end
               end
            end

            ACT_PIPE_DONE: begin
               if (phase_ff == PH_PIPE) begin
                  rsp_hit = 1'b1;
                  if (item.xfer_status != XS_SUCCESS) begin
                     rsp      = make_done(CC_RESET_FAILED);
                     phase_in = PH_IDLE;
                  end else if (csw_fits) begin
                     rsp      = make_cmd(CMD_STATUS, CSW_BYTES);
                     phase_in = PH_STATUS;
                  end else begin
                     rsp      = make_done(CC_INVALID);
                     phase_in = PH_IDLE;
                  end
               end
            end

            ACT_RECOVERY_DONE: begin
               if (phase_ff == PH_RECOVERY) begin
                  rsp_hit  = 1'b1;
                  rsp      = make_done((item.xfer_status == XS_SUCCESS) ?
                                       CC_DEV_ERROR : CC_RESET_FAILED);
                  phase_in = PH_IDLE;
               end
            end

            default: begin
               rsp_hit = 1'b0;
            end
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sense_ff     <= 1'b0;
         retry_ff     <= 1'b0;
         dir_ff       <= 1'b0;
         length_ff    <= '0;
         want_ff      <= 1'b0;
         sense_len_ff <= '0;
         lun_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         sense_ff     <= sense_in;
         retry_ff     <= retry_in;
         dir_ff       <= dir_in;
         length_ff    <= length_in;
         want_ff      <= want_in;
         sense_len_ff <= sense_len_in;
         lun_ff       <= lun_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/bulk_only_transport_sequencer.sv -----
// Bulk-only transport host sequencer: one event register, the phase sequencer,
// one result register. An event goes from the event register through the phase sequencer
// into the result register, where rsp_valid rises; rsp_ready sets the pace.
// Throughput: one event per cycle while the result register can take a result;
// an event without a result leaves the event register and sets no rsp_valid.
// Reset (synchronous): phase idle, request state cleared, registers at their defaults.
// Depends on bots_pkg, bots_csr and bots_core.
`default_nettype none

module bulk_only_transport_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   // event channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [1:0]  req_xfer_status,
   input  wire logic [31:0] req_byte_count,
   input  wire logic        req_dir_in,
   input  wire logic [3:0]  req_lun,
   input  wire logic [4:0]  req_cb_bytes,
   input  wire logic        req_want_sense,
   input  wire logic [7:0]  req_sense_length,
   input  wire logic        req_has_data,
   input  wire logic [31:0] req_status_sig,
   input  wire logic [7:0]  req_csw_status,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_command,
   output logic [31:0]      rsp_xfer_length,
   output logic             rsp_wrapper_dir_in,
   output logic [3:0]       rsp_wrapper_lun,
   output logic [4:0]       rsp_wrapper_cb_length,
   output logic             rsp_is_sense_wrapper,
   output logic [7:0]       rsp_sense_lun_byte,
   output logic [2:0]       rsp_complete_code,
   output logic             rsp_forge_good_sense,
   output logic             rsp_clear_pass_length,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import bots_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item_ff;
   logic         item_valid_ff, item_valid_in;
   logic         out_free;
   logic         fire;
   logic         core_hit;
   rsp_item_type core_rsp;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   assign req_item = '{action:        req_action,
                       xfer_status:   req_xfer_status,
                       byte_count:    req_byte_count,
                       dir_in:        req_dir_in,
                       lun:           req_lun,
                       cb_bytes:      req_cb_bytes,
                       want_sense:    req_want_sense,
                       sense_length:  req_sense_length,
                       has_data:      req_has_data,
                       status_sig:    req_status_sig,
                       csw_status:    req_csw_status};

   // Pipeline control: an event is processed when the result register can take its result
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || fire;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = core_hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Event register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   bots_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bots_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (item_ff),
      .cfg     (cfg),
      .rsp_hit (core_hit),
      .rsp     (core_rsp)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire && core_hit) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_command           = rsp_ff.command;
   assign rsp_xfer_length       = rsp_ff.xfer_length;
   assign rsp_wrapper_dir_in    = rsp_ff.wrapper_dir_in;
   assign rsp_wrapper_lun       = rsp_ff.wrapper_lun;
   assign rsp_wrapper_cb_length = rsp_ff.wrapper_cb_length;
   assign rsp_is_sense_wrapper  = rsp_ff.is_sense_wrapper;
   assign rsp_sense_lun_byte    = rsp_ff.sense_lun_byte;
   assign rsp_complete_code     = rsp_ff.complete_code;
   assign rsp_forge_good_sense  = rsp_ff.forge_good_sense;
   assign rsp_clear_pass_length = rsp_ff.clear_pass_length;

endmodule

`default_nettype wire

// ----- src/bots_checker.sv -----
// Port-level checks for the bulk-only transport sequencer, bound to the top level.
// Depends on bots_pkg.
`default_nettype none

module bots_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_command,
   input wire logic [31:0] rsp_xfer_length,
   input wire logic        rsp_wrapper_dir_in,
   input wire logic [3:0]  rsp_wrapper_lun,
   input wire logic [4:0]  rsp_wrapper_cb_length,
   input wire logic        rsp_is_sense_wrapper,
   input wire logic [2:0]  rsp_complete_code
);
   import bots_pkg::*;

   // no result is offered in the first cycle out of reset
   a_reset_quiet: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // a stalled result keeps its command and length
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command) &&
                                  $stable(rsp_xfer_length))
      else $error("stalled result changed");

   // completion codes only travel with a completion
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command != CMD_COMPLETE) |-> (rsp_complete_code == CC_SUCCESS))
      else $error("completion code on a bus command");

   // wrapper contents only travel with a send-wrapper command
   a_wrapper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command != CMD_WRAPPER) |->
         !rsp_wrapper_dir_in && (rsp_wrapper_lun == 4'd0) &&
         (rsp_wrapper_cb_length == 5'd0) && !rsp_is_sense_wrapper)
      else $error("wrapper fields on a non-wrapper command");

   // a status read always asks for one status wrapper
   a_status_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == CMD_STATUS) |-> (rsp_xfer_length == CSW_BYTES))
      else $error("status read with wrong length");

endmodule

bind bulk_only_transport_sequencer bots_checker u_bots_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_command           (rsp_command),
   .rsp_xfer_length       (rsp_xfer_length),
   .rsp_wrapper_dir_in    (rsp_wrapper_dir_in),
   .rsp_wrapper_lun       (rsp_wrapper_lun),
   .rsp_wrapper_cb_length (rsp_wrapper_cb_length),
   .rsp_is_sense_wrapper  (rsp_is_sense_wrapper),
   .rsp_complete_code     (rsp_complete_code)
);

`default_nettype wire

// ----- verif/bulk_only_transport_sequencer_tb.sv -----
// Testbench for the bulk-only transport sequencer: drives start and completion events,
// predicts each bus command or completion and checks it field by field.
// Depends on bots_pkg and the bulk_only_transport_sequencer RTL.

module bulk_only_transport_sequencer_tb;
   import bots_pkg::*;

   // Codes with no name in the package, plus bench limits
   localparam logic [1:0] XS_OTHER_ERROR = 2'd3;
   localparam logic [2:0] ACT_UNUSED_6   = 3'd6;
   localparam logic [2:0] ACT_UNUSED_7   = 3'd7;
   localparam int         DRAIN_CYCLES   = 8;
   localparam int         PRINT_CAP      = 200;

   // Scoreboard: tracks the transport phase and queues the expected results
   class transport_scoreboard;
      cfg_type      cfg;
      phase_type    phase;
      bit           in_sense;
      bit           retry_ok;
      bit           keep_dir_in;
      logic [31:0]  keep_length;
      bit           keep_want_sense;
      logic [7:0]   keep_sense_len;
      logic [3:0]   keep_lun;
      rsp_item_type expected_rsps[$];
      int           errors;

      function new();
         cfg.alt_sig_en = 1'b0;
         cfg.alt_sig    = '0;
         cfg.sense_form = SENSE_FORM_RST;
         cfg.max_length = MAX_LENGTH_RST;
         phase           = PH_IDLE;
         in_sense        = 1'b0;
         retry_ok        = 1'b0;
         keep_dir_in     = 1'b0;
         keep_length     = '0;
         keep_want_sense = 1'b0;
         keep_sense_len  = '0;
         keep_lun        = '0;
         errors          = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] data);
         case (index)
            CSR_ALT_SIG_EN: cfg.alt_sig_en = data[0];
            CSR_ALT_SIG:    cfg.alt_sig    = data;
            CSR_SENSE_FORM: cfg.sense_form = data[1:0];
            default:        cfg.max_length = data;
         endcase
      endfunction

      function rsp_item_type bus_cmd(logic [2:0] command, logic [31:0] len);
         rsp_item_type r;
         r = '0;
         r.command     = command;
         r.xfer_length = len;
         return r;
      endfunction

      // Completion ends the request
      function rsp_item_type done(logic [2:0] code);
         rsp_item_type r;
         r = bus_cmd(CMD_COMPLETE, '0);
         r.complete_code = code;
         phase = PH_IDLE;
         return r;
      endfunction

      function logic [2:0] fail_code(logic [1:0] xs);
         return (xs == XS_CANCELLED) ? CC_CANCELLED : CC_XFER_ERROR;
      endfunction

      function rsp_item_type status_read();
         if (CSW_BYTES > cfg.max_length)
            return done(CC_INVALID);
         phase = PH_STATUS;
         return bus_cmd(CMD_STATUS, CSW_BYTES);
      endfunction

      function rsp_item_type enter_recovery();
         phase = PH_RECOVERY;
         return bus_cmd(CMD_RECOVERY, '0);
      endfunction

      // Automatic request sense after a failed command
      function rsp_item_type sense_request();
         rsp_item_type r;
         logic [4:0]   cbl;
         if (keep_sense_len < SENSE_MIN)
            return done(CC_DEV_ERROR);
         if (cfg.sense_form == SENSE_FORM_LONG)
            cbl = SENSE_CB_LONG;
         else if (cfg.sense_form == SENSE_FORM_SHORT)
            cbl = SENSE_CB_SHORT;
         else
            return done(CC_DEV_ERROR);
         if (CBW_BYTES > cfg.max_length)
            return done(CC_DEV_ERROR);
         retry_ok    = 1'b1;
         in_sense    = 1'b1;
         phase       = PH_WRAPPER;
         r = bus_cmd(CMD_WRAPPER, {24'd0, keep_sense_len});
         r.wrapper_dir_in    = 1'b1;
         r.wrapper_lun       = '0;
         r.wrapper_cb_length = cbl;
         r.is_sense_wrapper  = 1'b1;
         r.sense_lun_byte    = {keep_lun[2:0], 5'd0};
         return r;
      endfunction

      // Advance the phase for one accepted event; returns 1 when a result is due
      function bit note_event(req_item_type ev);
         rsp_item_type r;
         bit           made;
         bit           sig_ok;
         logic [31:0]  len;
         r    = '0;
         made = 1'b1;
         if (ev.action == ACT_START) begin
            keep_length     = ev.byte_count;
            keep_dir_in     = ev.dir_in;
            keep_lun        = ev.lun;
            keep_want_sense = ev.want_sense;
            keep_sense_len  = ev.sense_length;
            retry_ok        = 1'b1;
            in_sense        = 1'b0;
            if (CBW_BYTES > cfg.max_length) begin
               r = done(CC_INVALID);
            end else begin
               phase = PH_WRAPPER;
               r = bus_cmd(CMD_WRAPPER, keep_length);
               r.wrapper_dir_in    = keep_dir_in;
               r.wrapper_lun       = keep_lun;
               r.wrapper_cb_length = ev.cb_bytes;
            end
         end else if (ev.action == ACT_WRAPPER_SENT && phase == PH_WRAPPER) begin
            len = in_sense ? {24'd0, keep_sense_len} : keep_length;
            if (ev.xfer_status == XS_STALLED)
               r = enter_recovery();
            else if (ev.xfer_status != XS_SUCCESS)
               r = done(fail_code(ev.xfer_status));
            else if (!ev.has_data)
               r = status_read();
            else if (len > cfg.max_length)
               r = done(CC_INVALID);
            else begin
               phase = PH_DATA;
               r = bus_cmd((in_sense || keep_dir_in) ? CMD_DATA_IN : CMD_DATA_OUT, len);
            end
         end else if (ev.action == ACT_DATA_DONE && phase == PH_DATA) begin
            if (ev.xfer_status == XS_SUCCESS) begin
               r = status_read();
            end else begin
               if (ev.xfer_status == XS_STALLED) begin
                  phase = PH_PIPE;
                  r = bus_cmd(CMD_CLEAR_PIPE, '0);
               end else begin
                  r = done(fail_code(ev.xfer_status));
               end
               r.clear_pass_length = 1'b1;
            end
         end else if (ev.action == ACT_STATUS_READ && phase == PH_STATUS) begin
            sig_ok = (ev.status_sig == CSW_GOOD_SIG) ||
                     (cfg.alt_sig_en && ev.status_sig == cfg.alt_sig);
            if (ev.xfer_status == XS_SUCCESS && sig_ok) begin
               if (ev.csw_status == 8'd0) begin
                  r = done(CC_SUCCESS);
                  r.forge_good_sense = !in_sense && keep_want_sense;
               end else if (ev.csw_status == 8'd1 && keep_want_sense && !in_sense) begin
                  r = sense_request();
               end else begin
                  r = enter_recovery();
               end
            end else if (ev.xfer_status == XS_STALLED && retry_ok) begin
               retry_ok = 1'b0;
               phase    = PH_PIPE;
               r = bus_cmd(CMD_CLEAR_PIPE, '0);
            end else if (ev.xfer_status != XS_CANCELLED) begin
               r = enter_recovery();
            end else begin
               r = done(CC_CANCELLED);
            end
         end else if (ev.action == ACT_PIPE_DONE && phase == PH_PIPE) begin
            r = (ev.xfer_status != XS_SUCCESS) ? done(CC_RESET_FAILED) : status_read();
         end else if (ev.action == ACT_RECOVERY_DONE && phase == PH_RECOVERY) begin
            r = done(ev.xfer_status == XS_SUCCESS ? CC_DEV_ERROR : CC_RESET_FAILED);
         end else begin
            made = 1'b0;
         end
         if (made)
            expected_rsps.push_back(r);
         return made;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
      endtask

      // Compare one result transfer against the oldest expectation
      task check_rsp(rsp_item_type got);
         rsp_item_type want;
         if (expected_rsps.size() == 0) begin
            report("result transfer with nothing expected");
            return;
         end
         want = expected_rsps.pop_front();
         compare_field("command", 32'(got.command), 32'(want.command));
         compare_field("xfer_length", got.xfer_length, want.xfer_length);
         compare_field("wrapper_dir_in", 32'(got.wrapper_dir_in), 32'(want.wrapper_dir_in));
         compare_field("wrapper_lun", 32'(got.wrapper_lun), 32'(want.wrapper_lun));
         compare_field("wrapper_cb_length", 32'(got.wrapper_cb_length),
                       32'(want.wrapper_cb_length));
         compare_field("is_sense_wrapper", 32'(got.is_sense_wrapper),
                       32'(want.is_sense_wrapper));
         compare_field("sense_lun_byte", 32'(got.sense_lun_byte), 32'(want.sense_lun_byte));
         compare_field("complete_code", 32'(got.complete_code), 32'(want.complete_code));
         compare_field("forge_good_sense", 32'(got.forge_good_sense),
                       32'(want.forge_good_sense));
         compare_field("clear_pass_length", 32'(got.clear_pass_length),
                       32'(want.clear_pass_length));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_action;
   logic [1:0]  req_xfer_status;
   logic [31:0] req_byte_count;
   logic        req_dir_in;
   logic [3:0]  req_lun;
   logic [4:0]  req_cb_bytes;
   logic        req_want_sense;
   logic [7:0]  req_sense_length;
   logic        req_has_data;
   logic [31:0] req_status_sig;
   logic [7:0]  req_csw_status;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_command;
   logic [31:0] rsp_xfer_length;
   logic        rsp_wrapper_dir_in;
   logic [3:0]  rsp_wrapper_lun;
   logic [4:0]  rsp_wrapper_cb_length;
   logic        rsp_is_sense_wrapper;
   logic [7:0]  rsp_sense_lun_byte;
   logic [2:0]  rsp_complete_code;
   logic        rsp_forge_good_sense;
   logic        rsp_clear_pass_length;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   transport_scoreboard sb;
   int                  hold_rsp_cycles;
   int                  burst_left;

   bulk_only_transport_sequencer dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_xfer_status       (req_xfer_status),
      .req_byte_count        (req_byte_count),
      .req_dir_in            (req_dir_in),
      .req_lun               (req_lun),
      .req_cb_bytes          (req_cb_bytes),
      .req_want_sense        (req_want_sense),
      .req_sense_length      (req_sense_length),
      .req_has_data          (req_has_data),
      .req_status_sig        (req_status_sig),
      .req_csw_status        (req_csw_status),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_command           (rsp_command),
      .rsp_xfer_length       (rsp_xfer_length),
      .rsp_wrapper_dir_in    (rsp_wrapper_dir_in),
      .rsp_wrapper_lun       (rsp_wrapper_lun),
      .rsp_wrapper_cb_length (rsp_wrapper_cb_length),
      .rsp_is_sense_wrapper  (rsp_is_sense_wrapper),
      .rsp_sense_lun_byte    (rsp_sense_lun_byte),
      .rsp_complete_code     (rsp_complete_code),
      .rsp_forge_good_sense  (rsp_forge_good_sense),
      .rsp_clear_pass_length (rsp_clear_pass_length),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [1:0] pick_status();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return XS_SUCCESS;
      if (r < 80)
         return XS_STALLED;
      if (r < 90)
         return XS_CANCELLED;
      return XS_OTHER_ERROR;
   endfunction

   function automatic req_item_type mk_start(logic [31:0] len, logic dir, logic [3:0] lun,
                                             logic [4:0] cdb, logic want, logic [7:0] slen);
      req_item_type ev;
      ev = '0;
      ev.action       = ACT_START;
      ev.byte_count   = len;
      ev.dir_in       = dir;
      ev.lun          = lun;
      ev.cb_bytes     = cdb;
      ev.want_sense   = want;
      ev.sense_length = slen;
      return ev;
   endfunction

   function automatic req_item_type mk_event(logic [2:0] action, logic [1:0] xs,
                                             logic has_data, logic [31:0] sig, logic [7:0] cst);
      req_item_type ev;
      ev = '0;
      ev.action        = action;
      ev.xfer_status   = xs;
      ev.has_data      = has_data;
      ev.status_sig    = sig;
      ev.csw_status    = cst;
      return ev;
   endfunction

   // Random event, mostly the one the current phase waits for
   function automatic req_item_type make_event();
      req_item_type ev;
      int unsigned  r;
      ev.xfer_status  = pick_status();
      ev.dir_in       = 1'($urandom_range(0, 1));
      ev.lun          = 4'($urandom_range(0, 15));
      ev.cb_bytes     = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(1, 16));
      ev.want_sense   = ($urandom_range(0, 9) < 7);
      ev.sense_length = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(18, 255))
                                                   : 8'($urandom_range(0, 17));
      ev.has_data     = ($urandom_range(0, 9) < 6);
      r = $urandom_range(0, 99);
      if (r < 50)
         ev.byte_count = 32'($urandom_range(0, 2048));
      else if (r < 65)
         ev.byte_count = sb.cfg.max_length + 32'($urandom_range(0, 2)) - 32'd1;
      else if (r < 80)
         ev.byte_count = $urandom;
      else if (r < 90)
         ev.byte_count = 32'hFFFF_FFFF;
      else
         ev.byte_count = '0;
      r = $urandom_range(0, 99);
      if (r < 75)
         ev.status_sig = CSW_GOOD_SIG;
      else if (r < 85)
         ev.status_sig = sb.cfg.alt_sig;
      else
         ev.status_sig = $urandom;
      r = $urandom_range(0, 99);
      if (r < 55)
         ev.csw_status = 8'd0;
      else if (r < 90)
         ev.csw_status = 8'd1;
      else
         ev.csw_status = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 5) begin
         ev.action = 3'($urandom_range(0, 7));
      end else if (sb.phase == PH_IDLE || r < 9) begin
         ev.action = ACT_START;
      end else begin
         case (sb.phase)
            PH_WRAPPER: ev.action = ACT_WRAPPER_SENT;
            PH_DATA:    ev.action = ACT_DATA_DONE;
            PH_STATUS:  ev.action = ACT_STATUS_READ;
            PH_PIPE:    ev.action = ACT_PIPE_DONE;
            default:    ev.action = ACT_RECOVERY_DONE;
         endcase
      end
      return ev;
   endfunction

   // Offer one event and wait for its transfer
   task send_event(input req_item_type ev, output bit produced);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0)
            burst_left = 30;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action        = ev.action;
      req_xfer_status   = ev.xfer_status;
      req_byte_count    = ev.byte_count;
      req_dir_in        = ev.dir_in;
      req_lun           = ev.lun;
      req_cb_bytes      = ev.cb_bytes;
      req_want_sense    = ev.want_sense;
      req_sense_length  = ev.sense_length;
      req_has_data      = ev.has_data;
      req_status_sig    = ev.status_sig;
      req_csw_status    = ev.csw_status;
      req_valid         = 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      produced = sb.note_event(ev);
   endtask

   // Stop offering and let every expected result come back
   task wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_csr(logic [1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      sb.write_reg(index, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task apply_config(logic alt_en, logic [31:0] alt_sig, logic [1:0] form, logic [31:0] max_len);
      write_csr(CSR_ALT_SIG_EN, {31'd0, alt_en});
      write_csr(CSR_ALT_SIG, alt_sig);
      write_csr(CSR_SENSE_FORM, {30'd0, form});
      write_csr(CSR_MAX_LENGTH, max_len);
   endtask

   // Random traffic until the given number of results is due
   task run_random(int results);
      req_item_type ev;
      bit           produced;
      int           count;
      count = 0;
      while (count < results) begin
         ev = make_event();
         send_event(ev, produced);
         if (produced)
            count++;
         if ($urandom_range(0, 199) == 0)
            wait_drained();
      end
      wait_drained();
   endtask

   // Result side: runs of ready broken by stalls, plus requested long hold-offs
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_rsp_cycles > 0) begin
            rsp_ready = 1'b0;
            repeat (hold_rsp_cycles) @(negedge clock);
            hold_rsp_cycles = 0;
         end
         rsp_ready = 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // Check every result transfer
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_command, rsp_xfer_length, rsp_wrapper_dir_in, rsp_wrapper_lun,
                rsp_wrapper_cb_length, rsp_is_sense_wrapper, rsp_sense_lun_byte,
                rsp_complete_code, rsp_forge_good_sense, rsp_clear_pass_length};
         sb.check_rsp(got);
      end
   end

   initial begin
      #30_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      req_item_type directed[$];
      bit           produced;
      sb = new();
      hold_rsp_cycles   = 0;
      burst_left        = 0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ACT_START;
      req_xfer_status   = XS_SUCCESS;
      req_byte_count    = '0;
      req_dir_in        = 1'b0;
      req_lun           = '0;
      req_cb_bytes      = '0;
      req_want_sense    = 1'b0;
      req_sense_length  = '0;
      req_has_data      = 1'b0;
      req_status_sig    = '0;
      req_csw_status    = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_ALT_SIG_EN;
      csr_wdata         = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed walk at reset settings
      // oversized data phase is refused
      directed.push_back(mk_start(32'hFFFF_FFFF, 1'b1, 4'd15, 5'd16, 1'b1, 8'd255));
      directed.push_back(mk_event(ACT_WRAPPER_SENT, XS_SUCCESS, 1'b1, '0, '0));
      // data stall, pipe clear, failed status, then sense with two status stalls
      directed.push_back(mk_start('0, 1'b0, 4'd0, 5'd1, 1'b1, 8'd18));
      directed.push_back(mk_event(ACT_WRAPPER_SENT, XS_SUCCESS, 1'b1, '0, '0));
      directed.push_back(mk_event(ACT_DATA_DONE, XS_STALLED, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_PIPE_DONE, XS_SUCCESS, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_STATUS_READ, XS_SUCCESS, 1'b0, CSW_GOOD_SIG, 8'd1));
      directed.push_back(mk_event(ACT_WRAPPER_SENT, XS_SUCCESS, 1'b1, '0, '0));
      directed.push_back(mk_event(ACT_DATA_DONE, XS_SUCCESS, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_STATUS_READ, XS_STALLED, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_PIPE_DONE, XS_SUCCESS, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_STATUS_READ, XS_STALLED, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_RECOVERY_DONE, XS_SUCCESS, 1'b0, '0, '0));
      // ignored events
      directed.push_back(mk_event(ACT_UNUSED_6, XS_STALLED, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_UNUSED_7, XS_SUCCESS, 1'b1, CSW_GOOD_SIG, '0));
      directed.push_back(mk_event(ACT_STATUS_READ, XS_SUCCESS, 1'b0, CSW_GOOD_SIG, '0));
      // bad signature leads to recovery, which then fails
      directed.push_back(mk_start(32'd100, 1'b1, 4'd9, 5'd10, 1'b1, 8'd17));
      directed.push_back(mk_event(ACT_WRAPPER_SENT, XS_SUCCESS, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_STATUS_READ, XS_SUCCESS, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_RECOVERY_DONE, XS_OTHER_ERROR, 1'b0, '0, '0));
      // sense buffer too short
      directed.push_back(mk_start(32'd7, 1'b0, 4'd3, 5'd6, 1'b1, 8'd17));
      directed.push_back(mk_event(ACT_WRAPPER_SENT, XS_SUCCESS, 1'b0, '0, '0));
      directed.push_back(mk_event(ACT_STATUS_READ, XS_SUCCESS, 1'b0, CSW_GOOD_SIG, 8'd1));
      // start while busy, then cancelled wrapper
      directed.push_back(mk_start(32'd64, 1'b1, 4'd1, 5'd12, 1'b0, 8'd32));
      directed.push_back(mk_start(32'd65536, 1'b0, 4'd2, 5'd31, 1'b0, 8'd0));
      directed.push_back(mk_event(ACT_WRAPPER_SENT, XS_CANCELLED, 1'b1, '0, '0));
      foreach (directed[i])
         send_event(directed[i], produced);
      wait_drained();

      // Random phases across register settings
      apply_config(1'b1, $urandom, SENSE_FORM_LONG, MAX_LENGTH_RST);
      run_random(500);
      apply_config(1'b0, 32'hFFFF_FFFF, SENSE_FORM_SHORT, 32'hFFFF_FFFF);
      hold_rsp_cycles = 250;
      run_random(500);
      apply_config(1'b1, CSW_GOOD_SIG + 32'd1, 2'd3, CBW_BYTES - 32'd1);
      run_random(60);
      apply_config(1'b0, '0, SENSE_FORM_LONG, '0);
      run_random(60);
      apply_config(1'b1, $urandom, 2'd2, CBW_BYTES);
      run_random(330);
      apply_config(1'b1, '0, SENSE_FORM_SHORT, 32'($urandom_range(32, 5000)));
      run_random(500);

      wait_drained();
      if (sb.errors == 0 && sb.expected_rsps.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/bots_pkg.sv
src/bots_csr.sv
src/bots_core.sv
src/bulk_only_transport_sequencer.sv
src/bots_checker.sv
verif/bulk_only_transport_sequencer_tb.sv
